// ===== design/arqsw_pkg.sv =====
// Shared constants for the ARQ send window unit: window size, field widths,
// command and result kind codes. No dependencies.

package arqsw_pkg;

   localparam int WINDOW_SLOTS = 32;
   localparam int SEQ_W        = 32;
   localparam int IDX_W        = $clog2(WINDOW_SLOTS);
   localparam int CNT_W        = $clog2(WINDOW_SLOTS + 1);

   typedef logic [SEQ_W-1:0] seq_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [1:0]       code_type;

   localparam code_type CMD_ADD  = 2'd0;
   localparam code_type CMD_ACK  = 2'd1;
   localparam code_type CMD_NAK  = 2'd2;
   localparam code_type CMD_TICK = 2'd3;

   localparam code_type KIND_SEND   = 2'd0;
   localparam code_type KIND_ACKACK = 2'd1;
   localparam code_type KIND_STATUS = 2'd2;

endpackage

// ===== design/arq_send_window_unit.sv =====
// ARQ send window unit: top level with window state, sequencer, shared adder
// and result register. Depends on arqsw_pkg.
//
// Usage: commands (add, ack, nak, tick) enter on the req_ channel one at a
// time; req_ready is high only while the sequencer is idle. Each item gives
// its results on the rsp_ channel in order: the ack-of-ack (ack only), one
// send per lost window entry in window order, and a status result with
// rsp_last set. The csr_ port loads the start sequence number and empties
// the window; write it only while the block is idle.
// Operation: one shared 32-bit adder does all sequence arithmetic and the
// sequencer walks the window one slot a cycle, except while a send waits
// for a full result register. An add or tick makes a send pass and then
// gives the status result; an ack first slides the window, and a nak does
// span and offset set-up, a marking pass and a send pass. The earliest
// result passes through the sequencer state register and then the result
// register. A stalled receiver holds the steps that write a result while the
// result register is full and rsp_ready is low. A new item may be accepted
// while the status result still waits in the result register.
// Reset (synchronous, active high) empties the window with base zero and
// drops any pending result.

module arq_send_window_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_command,
   input  logic [arqsw_pkg::SEQ_W-1:0] req_seq_number,
   input  logic [arqsw_pkg::SEQ_W-1:0] req_seq_range_end,
   input  logic [arqsw_pkg::SEQ_W-1:0] req_ack_number,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_kind,
   output logic [arqsw_pkg::SEQ_W-1:0] rsp_packet_seq,
   output logic [arqsw_pkg::SEQ_W-1:0] rsp_echo_ack,
   output logic                        rsp_accepted,
   output logic                        rsp_flushed,
   output logic [arqsw_pkg::SEQ_W-1:0] rsp_next_seq,
   output logic                        rsp_last,
   input  logic                        csr_write_enable,
   input  logic [arqsw_pkg::SEQ_W-1:0] csr_write_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ACK    = 3'd1;
   localparam logic [2:0] ST_SPAN   = 3'd2;
   localparam logic [2:0] ST_OFFSET = 3'd3;
   localparam logic [2:0] ST_NAK    = 3'd4;
   localparam logic [2:0] ST_SEND   = 3'd5;
   localparam logic [2:0] ST_STATUS = 3'd6;

   logic [2:0]                          state_ff, state_in;
   arqsw_pkg::seq_type                  base_ff, base_in;
   arqsw_pkg::cnt_type                  count_ff, count_in;
   logic [arqsw_pkg::WINDOW_SLOTS-1:0]  lost_ff, lost_in;
   arqsw_pkg::cnt_type                  idx_ff, idx_in;
   arqsw_pkg::seq_type                  seq_ff, seq_in;
   arqsw_pkg::seq_type                  rend_ff, rend_in;
   arqsw_pkg::seq_type                  ackn_ff, ackn_in;
   arqsw_pkg::seq_type                  span_ff, span_in;
   arqsw_pkg::seq_type                  dist_ff, dist_in;
   logic                                taken_ff, taken_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   arqsw_pkg::code_type                 rsp_kind_ff, rsp_kind_in;
   arqsw_pkg::seq_type                  rsp_pseq_ff, rsp_pseq_in;
   arqsw_pkg::seq_type                  rsp_echo_ff, rsp_echo_in;
   logic                                rsp_acc_ff, rsp_acc_in;
   logic                                rsp_flush_ff, rsp_flush_in;
   arqsw_pkg::seq_type                  rsp_next_ff, rsp_next_in;
   logic                                rsp_last_ff, rsp_last_in;

   arqsw_pkg::seq_type                  alu_a, alu_b, alu_sum;
   logic                                alu_cin;
   logic                                out_free;
   logic                                idx_end;
   logic [arqsw_pkg::IDX_W-1:0]         slot;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign idx_end  = (idx_ff >= count_ff);
   assign slot     = idx_ff[arqsw_pkg::IDX_W-1:0];
   assign alu_sum  = alu_a + alu_b + {{(arqsw_pkg::SEQ_W-1){1'b0}}, alu_cin};

   // shared adder: operand selection by sequencer state
   always_comb begin
      alu_a   = base_ff;
      alu_b   = {{(arqsw_pkg::SEQ_W-arqsw_pkg::CNT_W){1'b0}}, idx_ff};
      alu_cin = 1'b0;
      case (state_ff)
         ST_ACK: begin
            alu_a   = seq_ff;
            alu_b   = ~base_ff;
            alu_cin = 1'b1;
         end
         ST_SPAN: begin
            alu_a   = rend_ff;
            alu_b   = ~seq_ff;
            alu_cin = 1'b1;
         end
         ST_OFFSET: begin
            alu_a   = base_ff;
            alu_b   = ~seq_ff;
            alu_cin = 1'b1;
         end
         ST_NAK: begin
            alu_a   = dist_ff;
            alu_b   = '0;
            alu_cin = 1'b1;
         end
         ST_STATUS: begin
            alu_a = base_ff;
            alu_b = {{(arqsw_pkg::SEQ_W-arqsw_pkg::CNT_W){1'b0}}, count_ff};
         end
         default: begin
            alu_a = base_ff;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      count_in     = count_ff;
      lost_in      = lost_ff;
      idx_in       = idx_ff;
      seq_in       = seq_ff;
      rend_in      = rend_ff;
      ackn_in      = ackn_ff;
      span_in      = span_ff;
      dist_in      = dist_ff;
      taken_in     = taken_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_pseq_in  = rsp_pseq_ff;
      rsp_echo_in  = rsp_echo_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_flush_in = rsp_flush_ff;
      rsp_next_in  = rsp_next_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               seq_in   = req_seq_number;
               rend_in  = req_seq_range_end;
               ackn_in  = req_ack_number;
               idx_in   = '0;
               taken_in = 1'b0;
               case (req_command)
                  arqsw_pkg::CMD_ADD: begin
                     if (count_ff < arqsw_pkg::cnt_type'(arqsw_pkg::WINDOW_SLOTS)) begin
                        lost_in[count_ff[arqsw_pkg::IDX_W-1:0]] = 1'b1;
                        count_in = count_ff + 1'b1;
                        taken_in = 1'b1;
                     end
                     state_in = ST_SEND;
                  end
                  arqsw_pkg::CMD_ACK: state_in = ST_ACK;
                  arqsw_pkg::CMD_NAK: state_in = ST_SPAN;
                  default: begin
                     for (int i = 0; i < arqsw_pkg::WINDOW_SLOTS; i++) begin
                        lost_in[i] = (arqsw_pkg::cnt_type'(i) < count_ff);
                     end
                     state_in = ST_SEND;
                  end
               endcase
            end
         end
         ST_ACK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = arqsw_pkg::KIND_ACKACK;
               rsp_pseq_in  = '0;
               rsp_echo_in  = ackn_ff;
               rsp_acc_in   = 1'b0;
               rsp_flush_in = 1'b0;
               rsp_next_in  = '0;
               rsp_last_in  = 1'b0;
               if (alu_sum <= {{(arqsw_pkg::SEQ_W-arqsw_pkg::CNT_W){1'b0}}, count_ff}) begin
                  lost_in  = lost_ff >> alu_sum[arqsw_pkg::CNT_W-1:0];
                  base_in  = seq_ff;
                  count_in = count_ff - alu_sum[arqsw_pkg::CNT_W-1:0];
               end
               state_in = ST_SEND;
            end
         end
         ST_SPAN: begin
            span_in  = alu_sum;
            state_in = ST_OFFSET;
         end
         ST_OFFSET: begin
            dist_in  = alu_sum;
            state_in = ST_NAK;
         end
         ST_NAK: begin
            if (idx_end) begin
               idx_in   = '0;
               state_in = ST_SEND;
            end else begin
               if (dist_ff <= span_ff) begin
                  lost_in[slot] = 1'b1;
               end
               dist_in = alu_sum;
               idx_in  = idx_ff + 1'b1;
            end
         end
         ST_SEND: begin
            if (idx_end) begin
               state_in = ST_STATUS;
            end else if (!lost_ff[slot]) begin
               idx_in = idx_ff + 1'b1;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = arqsw_pkg::KIND_SEND;
               rsp_pseq_in   = alu_sum;
               rsp_echo_in   = '0;
               rsp_acc_in    = 1'b0;
               rsp_flush_in  = 1'b0;
               rsp_next_in   = '0;
               rsp_last_in   = 1'b0;
               lost_in[slot] = 1'b0;
               idx_in        = idx_ff + 1'b1;
            end
         end
         ST_STATUS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = arqsw_pkg::KIND_STATUS;
               rsp_pseq_in  = '0;
               rsp_echo_in  = '0;
               rsp_acc_in   = taken_ff;
               rsp_flush_in = (count_ff == '0);
               rsp_next_in  = alu_sum;
               rsp_last_in  = 1'b1;
               lost_in      = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_write_enable) begin
         base_in  = csr_write_data;
         count_in = '0;
         lost_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         count_ff     <= '0;
         lost_ff      <= '0;
         idx_ff       <= '0;
         taken_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         count_ff     <= count_in;
         lost_ff      <= lost_in;
         idx_ff       <= idx_in;
         taken_ff     <= taken_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff       <= seq_in;
      rend_ff      <= rend_in;
      ackn_ff      <= ackn_in;
      span_ff      <= span_in;
      dist_ff      <= dist_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_pseq_ff  <= rsp_pseq_in;
      rsp_echo_ff  <= rsp_echo_in;
      rsp_acc_ff   <= rsp_acc_in;
      rsp_flush_ff <= rsp_flush_in;
      rsp_next_ff  <= rsp_next_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_packet_seq = rsp_pseq_ff;
   assign rsp_echo_ack   = rsp_echo_ff;
   assign rsp_accepted   = rsp_acc_ff;
   assign rsp_flushed    = rsp_flush_ff;
   assign rsp_next_seq   = rsp_next_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

// ===== design/arqsw_checker.sv =====
// Port-level checker for the ARQ send window unit, bound to its top level.
// Depends on arqsw_pkg and arq_send_window_unit.

module arqsw_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  rsp_kind,
   input logic [arqsw_pkg::SEQ_W-1:0] rsp_packet_seq,
   input logic                        rsp_accepted,
   input logic                        rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_packet_seq) && $stable(rsp_last))
      else $error("stalled result item changed");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in flight");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result item produced with no item in flight");

   a_accept_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_last && (rsp_kind == arqsw_pkg::KIND_STATUS))
      else $error("accepted flag outside the status item");

endmodule

bind arq_send_window_unit arqsw_checker u_arqsw_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_kind       (rsp_kind),
   .rsp_packet_seq (rsp_packet_seq),
   .rsp_accepted   (rsp_accepted),
   .rsp_last       (rsp_last)
);
